/* rtl/ecsm_pkg.sv */
// Shared types, constants, field helpers and microcode for the curve scalar multiplier.
package ecsm_pkg;

  localparam int WORD_BITS = 32;
  localparam int CNT_BITS  = $clog2(WORD_BITS);

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [4:0]           raddr_t;
  typedef logic [5:0]           pc_t;
  typedef logic [CNT_BITS-1:0]  bitcnt_t;

  localparam logic [1:0] CFG_MODULUS = 2'd0;
  localparam logic [1:0] CFG_COEFF_A = 2'd1;
  localparam logic [1:0] CFG_COEFF_B = 2'd2;

  typedef enum logic [3:0] {
    OP_NOP, OP_MOV, OP_ADD, OP_SUB, OP_MUL, OP_RED, OP_ONE, OP_LDE, OP_SHE, OP_OUT
  } op_t;

  typedef enum logic [3:0] {
    BR_NONE, BR_ALWAYS, BR_KZ, BR_NLAST, BR_CALL, BR_RET, BR_END,
    BR_PINF1, BR_PINF2, BR_NE, BR_Z1, BR_EZ, BR_E0Z
  } br_t;

  typedef enum logic [3:0] {
    FL_NONE, FL_ONC, FL_INIT, FL_PACC, FL_ACCW, FL_PDBL, FL_CURW, FL_KSH,
    FL_P3FIN, FL_P3INF, FL_P3P2
  } fl_t;

  // Register file map
  localparam raddr_t R_X   = 5'd0;
  localparam raddr_t R_Y   = 5'd1;
  localparam raddr_t R_A   = 5'd2;
  localparam raddr_t R_B   = 5'd3;
  localparam raddr_t R_AX  = 5'd4;
  localparam raddr_t R_AY  = 5'd5;
  localparam raddr_t R_CX  = 5'd6;
  localparam raddr_t R_CY  = 5'd7;
  localparam raddr_t R_P1X = 5'd8;
  localparam raddr_t R_P1Y = 5'd9;
  localparam raddr_t R_P2X = 5'd10;
  localparam raddr_t R_P2Y = 5'd11;
  localparam raddr_t R_P3X = 5'd12;
  localparam raddr_t R_P3Y = 5'd13;
  localparam raddr_t R_T0  = 5'd14;
  localparam raddr_t R_T1  = 5'd15;
  localparam raddr_t R_T2  = 5'd16;
  localparam raddr_t R_T3  = 5'd17;
  localparam raddr_t R_T4  = 5'd18;
  localparam raddr_t R_T5  = 5'd19;

  // Raw operand selects for the reduction op
  localparam raddr_t RAW_X = 5'd0;
  localparam raddr_t RAW_Y = 5'd1;
  localparam raddr_t RAW_A = 5'd2;
  localparam raddr_t RAW_B = 5'd3;

  // Program labels
  localparam pc_t PC_LOOP  = 6'd13;
  localparam pc_t PC_DBL   = 6'd20;
  localparam pc_t PC_FIN   = 6'd26;
  localparam pc_t PC_ADDPT = 6'd27;
  localparam pc_t PC_DIST  = 6'd37;
  localparam pc_t PC_INV   = 6'd39;
  localparam pc_t PC_ILOOP = 6'd42;
  localparam pc_t PC_ISQ   = 6'd45;
  localparam pc_t PC_SLOPE = 6'd47;
  localparam pc_t PC_PINF  = 6'd54;
  localparam pc_t PC_CPY2  = 6'd55;
  localparam pc_t PC_CPY1  = 6'd57;

  typedef struct packed {
    op_t    op;
    raddr_t dst;
    raddr_t s1;
    raddr_t s2;
    br_t    br;
    fl_t    fl;
    pc_t    tgt;
  } uins_t;

  typedef struct packed {
    logic   go;
    logic   load;
    op_t    op;
    raddr_t dst;
    raddr_t s1;
    raddr_t s2;
  } cmd_t;

  typedef struct packed {
    logic eq;
    logic z1;
    logic ez;
    logic e0;
    logic mul_done;
    logic m_small;
  } sts_t;

  // Both operands below m.
  function automatic word_t fadd(word_t u, word_t v, word_t m);
    logic [WORD_BITS:0] s;
    s = {1'b0, u} + {1'b0, v};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[WORD_BITS-1:0];
  endfunction

  function automatic word_t fsub(word_t u, word_t v, word_t m);
    logic [WORD_BITS:0] s;
    s = {1'b0, u} - {1'b0, v};
    if (u < v) begin
      s = s + {1'b0, m};
    end
    return s[WORD_BITS-1:0];
  endfunction

  function automatic uins_t mk(op_t op, raddr_t dst, raddr_t s1, raddr_t s2, br_t br,
                               fl_t fl, pc_t tgt);
    uins_t u;
    u.op  = op;
    u.dst = dst;
    u.s1  = s1;
    u.s2  = s2;
    u.br  = br;
    u.fl  = fl;
    u.tgt = tgt;
    return u;
  endfunction

  function automatic uins_t ucode(pc_t pc);
    uins_t u;
    case (pc)
      6'd0:  u = mk(OP_RED, R_X, RAW_X, R_X, BR_NONE, FL_NONE, PC_FIN);
      6'd1:  u = mk(OP_RED, R_Y, RAW_Y, R_X, BR_NONE, FL_NONE, PC_FIN);
      6'd2:  u = mk(OP_RED, R_A, RAW_A, R_X, BR_NONE, FL_NONE, PC_FIN);
      6'd3:  u = mk(OP_RED, R_B, RAW_B, R_X, BR_NONE, FL_NONE, PC_FIN);
      6'd4:  u = mk(OP_MUL, R_T0, R_Y, R_Y, BR_NONE, FL_NONE, PC_FIN);
      6'd5:  u = mk(OP_MUL, R_T1, R_X, R_X, BR_NONE, FL_NONE, PC_FIN);
      6'd6:  u = mk(OP_MUL, R_T1, R_T1, R_X, BR_NONE, FL_NONE, PC_FIN);
      6'd7:  u = mk(OP_MUL, R_T2, R_A, R_X, BR_NONE, FL_NONE, PC_FIN);
      6'd8:  u = mk(OP_ADD, R_T1, R_T1, R_T2, BR_NONE, FL_NONE, PC_FIN);
      6'd9:  u = mk(OP_ADD, R_T1, R_T1, R_B, BR_NONE, FL_NONE, PC_FIN);
      6'd10: u = mk(OP_NOP, R_T0, R_T0, R_T1, BR_NONE, FL_ONC, PC_FIN);
      6'd11: u = mk(OP_MOV, R_CX, R_X, R_X, BR_NONE, FL_INIT, PC_FIN);
      6'd12: u = mk(OP_MOV, R_CY, R_Y, R_Y, BR_NONE, FL_NONE, PC_FIN);
      // Scalar bit loop
      6'd13: u = mk(OP_NOP, R_T0, R_T0, R_T0, BR_KZ, FL_NONE, PC_DBL);
      6'd14: u = mk(OP_MOV, R_P1X, R_AX, R_AX, BR_NONE, FL_PACC, PC_FIN);
      6'd15: u = mk(OP_MOV, R_P1Y, R_AY, R_AY, BR_NONE, FL_NONE, PC_FIN);
      6'd16: u = mk(OP_MOV, R_P2X, R_CX, R_CX, BR_NONE, FL_NONE, PC_FIN);
      6'd17: u = mk(OP_MOV, R_P2Y, R_CY, R_CY, BR_CALL, FL_NONE, PC_ADDPT);
      6'd18: u = mk(OP_MOV, R_AX, R_P3X, R_P3X, BR_NONE, FL_ACCW, PC_FIN);
      6'd19: u = mk(OP_MOV, R_AY, R_P3Y, R_P3Y, BR_NONE, FL_NONE, PC_FIN);
      6'd20: u = mk(OP_MOV, R_P1X, R_CX, R_CX, BR_NONE, FL_PDBL, PC_FIN);
      6'd21: u = mk(OP_MOV, R_P1Y, R_CY, R_CY, BR_NONE, FL_NONE, PC_FIN);
      6'd22: u = mk(OP_MOV, R_P2X, R_CX, R_CX, BR_NONE, FL_NONE, PC_FIN);
      6'd23: u = mk(OP_MOV, R_P2Y, R_CY, R_CY, BR_CALL, FL_NONE, PC_ADDPT);
      6'd24: u = mk(OP_MOV, R_CX, R_P3X, R_P3X, BR_NONE, FL_CURW, PC_FIN);
      6'd25: u = mk(OP_MOV, R_CY, R_P3Y, R_P3Y, BR_NLAST, FL_KSH, PC_LOOP);
      6'd26: u = mk(OP_OUT, R_T0, R_AX, R_AY, BR_END, FL_NONE, PC_FIN);
      // Point addition subroutine: P3 = P1 + P2
      6'd27: u = mk(OP_NOP, R_T0, R_T0, R_T0, BR_PINF1, FL_NONE, PC_CPY2);
      6'd28: u = mk(OP_NOP, R_T0, R_T0, R_T0, BR_PINF2, FL_NONE, PC_CPY1);
      6'd29: u = mk(OP_NOP, R_T0, R_P1X, R_P2X, BR_NE, FL_NONE, PC_DIST);
      6'd30: u = mk(OP_NOP, R_T0, R_P1Y, R_P2Y, BR_NE, FL_NONE, PC_PINF);
      6'd31: u = mk(OP_NOP, R_T0, R_P1Y, R_P1Y, BR_Z1, FL_NONE, PC_PINF);
      6'd32: u = mk(OP_MUL, R_T0, R_P1X, R_P1X, BR_NONE, FL_NONE, PC_FIN);
      6'd33: u = mk(OP_ADD, R_T1, R_T0, R_T0, BR_NONE, FL_NONE, PC_FIN);
      6'd34: u = mk(OP_ADD, R_T1, R_T1, R_T0, BR_NONE, FL_NONE, PC_FIN);
      6'd35: u = mk(OP_ADD, R_T1, R_T1, R_A, BR_NONE, FL_NONE, PC_FIN);
      6'd36: u = mk(OP_ADD, R_T2, R_P1Y, R_P1Y, BR_ALWAYS, FL_NONE, PC_INV);
      6'd37: u = mk(OP_SUB, R_T1, R_P2Y, R_P1Y, BR_NONE, FL_NONE, PC_FIN);
      6'd38: u = mk(OP_SUB, R_T2, R_P2X, R_P1X, BR_NONE, FL_NONE, PC_FIN);
      // Fermat inversion of T2 into T3
      6'd39: u = mk(OP_ONE, R_T3, R_T0, R_T0, BR_NONE, FL_NONE, PC_FIN);
      6'd40: u = mk(OP_LDE, R_T0, R_T0, R_T0, BR_NONE, FL_NONE, PC_FIN);
      6'd41: u = mk(OP_MOV, R_T4, R_T2, R_T2, BR_NONE, FL_NONE, PC_FIN);
      6'd42: u = mk(OP_NOP, R_T0, R_T0, R_T0, BR_EZ, FL_NONE, PC_SLOPE);
      6'd43: u = mk(OP_NOP, R_T0, R_T0, R_T0, BR_E0Z, FL_NONE, PC_ISQ);
      6'd44: u = mk(OP_MUL, R_T3, R_T3, R_T4, BR_NONE, FL_NONE, PC_FIN);
      6'd45: u = mk(OP_MUL, R_T4, R_T4, R_T4, BR_NONE, FL_NONE, PC_FIN);
      6'd46: u = mk(OP_SHE, R_T0, R_T0, R_T0, BR_ALWAYS, FL_NONE, PC_ILOOP);
      6'd47: u = mk(OP_MUL, R_T5, R_T1, R_T3, BR_NONE, FL_NONE, PC_FIN);
      6'd48: u = mk(OP_MUL, R_T0, R_T5, R_T5, BR_NONE, FL_NONE, PC_FIN);
      6'd49: u = mk(OP_SUB, R_T0, R_T0, R_P1X, BR_NONE, FL_NONE, PC_FIN);
      6'd50: u = mk(OP_SUB, R_P3X, R_T0, R_P2X, BR_NONE, FL_NONE, PC_FIN);
      6'd51: u = mk(OP_SUB, R_T0, R_P1X, R_P3X, BR_NONE, FL_NONE, PC_FIN);
      6'd52: u = mk(OP_MUL, R_T0, R_T5, R_T0, BR_NONE, FL_NONE, PC_FIN);
      6'd53: u = mk(OP_SUB, R_P3Y, R_T0, R_P1Y, BR_RET, FL_P3FIN, PC_FIN);
      6'd54: u = mk(OP_NOP, R_T0, R_T0, R_T0, BR_RET, FL_P3INF, PC_FIN);
      6'd55: u = mk(OP_MOV, R_P3X, R_P2X, R_P2X, BR_NONE, FL_NONE, PC_FIN);
      6'd56: u = mk(OP_MOV, R_P3Y, R_P2Y, R_P2Y, BR_RET, FL_P3P2, PC_FIN);
      6'd57: u = mk(OP_MOV, R_P3X, R_P1X, R_P1X, BR_NONE, FL_NONE, PC_FIN);
      6'd58: u = mk(OP_MOV, R_P3Y, R_P1Y, R_P1Y, BR_RET, FL_P3FIN, PC_FIN);
      default: u = mk(OP_NOP, R_T0, R_T0, R_T0, BR_END, FL_NONE, PC_FIN);
    endcase
    return u;
  endfunction

endpackage

/* rtl/ecsm_dp.sv */
// Datapath: configuration registers, register file, modular add/sub and serial multiplier.
module ecsm_dp (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic [1:0]            cfg_index,
  input  ecsm_pkg::word_t       cfg_data,
  input  ecsm_pkg::word_t       point_x,
  input  ecsm_pkg::word_t       point_y,
  input  ecsm_pkg::cmd_t        cmd,
  output ecsm_pkg::sts_t        sts,
  output ecsm_pkg::word_t       res_x,
  output ecsm_pkg::word_t       res_y
);

  ecsm_pkg::word_t modulus;
  ecsm_pkg::word_t coeff_a;
  ecsm_pkg::word_t coeff_b;
  ecsm_pkg::word_t raw_x;
  ecsm_pkg::word_t raw_y;
  ecsm_pkg::word_t mem [32];
  ecsm_pkg::word_t rd1;
  ecsm_pkg::word_t rd2;
  ecsm_pkg::word_t expo;
  ecsm_pkg::word_t mu;
  ecsm_pkg::word_t mv;
  ecsm_pkg::word_t mr;
  logic [ecsm_pkg::CNT_BITS:0] mcnt;
  logic            mbusy;
  logic            mul_done;
  logic            mul_start;
  ecsm_pkg::word_t mstep;
  ecsm_pkg::word_t mnext;
  ecsm_pkg::word_t raw_sel;
  logic            we;
  ecsm_pkg::word_t wdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= ecsm_pkg::word_t'(23);
      coeff_a <= ecsm_pkg::word_t'(1);
      coeff_b <= ecsm_pkg::word_t'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        ecsm_pkg::CFG_MODULUS: modulus <= cfg_data;
        ecsm_pkg::CFG_COEFF_A: coeff_a <= cfg_data;
        ecsm_pkg::CFG_COEFF_B: coeff_b <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      raw_x <= point_x;
      raw_y <= point_y;
    end
  end

  always_comb begin
    case (cmd.s1[1:0])
      ecsm_pkg::RAW_X[1:0]: raw_sel = raw_x;
      ecsm_pkg::RAW_Y[1:0]: raw_sel = raw_y;
      ecsm_pkg::RAW_A[1:0]: raw_sel = coeff_a;
      default:              raw_sel = coeff_b;
    endcase
  end

  // Multiplier: doubling on even steps, conditional add of mu on odd steps, MSB first.
  assign mul_start = cmd.go && (cmd.op == ecsm_pkg::OP_MUL || cmd.op == ecsm_pkg::OP_RED);
  assign mul_done  = mbusy && (mcnt == '1);
  assign mstep     = ecsm_pkg::fadd(mr, mcnt[0] ? mu : mr, modulus);
  assign mnext     = (mcnt[0] && !mv[ecsm_pkg::WORD_BITS-1]) ? mr : mstep;

  always_ff @(posedge clk) begin
    if (rst) begin
      mbusy <= 1'b0;
      mcnt  <= '0;
    end else if (mul_start) begin
      mbusy <= 1'b1;
      mcnt  <= '0;
    end else if (mbusy) begin
      mcnt <= mcnt + 1'b1;
      if (mul_done) begin
        mbusy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mul_start) begin
      mu <= (cmd.op == ecsm_pkg::OP_RED) ? ecsm_pkg::word_t'(1) : rd1;
      mv <= (cmd.op == ecsm_pkg::OP_RED) ? raw_sel : rd2;
      mr <= '0;
    end else if (mbusy) begin
      mr <= mnext;
      if (mcnt[0]) begin
        mv <= {mv[ecsm_pkg::WORD_BITS-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    we    = 1'b0;
    wdata = mnext;
    if (mul_done) begin
      we = 1'b1;
    end else if (cmd.go) begin
      case (cmd.op)
        ecsm_pkg::OP_MOV: begin
          we    = 1'b1;
          wdata = rd1;
        end
        ecsm_pkg::OP_ADD: begin
          we    = 1'b1;
          wdata = ecsm_pkg::fadd(rd1, rd2, modulus);
        end
        ecsm_pkg::OP_SUB: begin
          we    = 1'b1;
          wdata = ecsm_pkg::fsub(rd1, rd2, modulus);
        end
        ecsm_pkg::OP_ONE: begin
          we    = 1'b1;
          wdata = ecsm_pkg::word_t'(1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rd1 <= mem[cmd.s1];
    rd2 <= mem[cmd.s2];
    if (we) begin
      mem[cmd.dst] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.go) begin
      case (cmd.op)
        ecsm_pkg::OP_LDE: expo <= modulus - ecsm_pkg::word_t'(2);
        ecsm_pkg::OP_SHE: expo <= expo >> 1;
        ecsm_pkg::OP_OUT: begin
          res_x <= rd1;
          res_y <= rd2;
        end
        default: ;
      endcase
    end
  end

  assign sts.eq       = (rd1 == rd2);
  assign sts.z1       = (rd1 == '0);
  assign sts.ez       = (expo == '0);
  assign sts.e0       = expo[0];
  assign sts.mul_done = mul_done;
  assign sts.m_small  = (modulus < ecsm_pkg::word_t'(3));

endmodule

/* rtl/ecsm_ctrl.sv */
// Controller: microcode sequencer, point flags, scalar bits and the item handshake.
module ecsm_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  ecsm_pkg::word_t scalar,
  output logic            out_valid,
  input  logic            out_stall,
  output ecsm_pkg::cmd_t  cmd,
  input  ecsm_pkg::sts_t  sts,
  output logic            res_inf,
  output logic            on_curve
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_FETCH = 5'b00010,
    S_EXEC  = 5'b00100,
    S_WAIT  = 5'b01000,
    S_HOLD  = 5'b10000
  } state_t;

  state_t              state;
  ecsm_pkg::pc_t       pc;
  ecsm_pkg::pc_t       pc_next;
  ecsm_pkg::pc_t       ret;
  ecsm_pkg::uins_t     ins;
  ecsm_pkg::word_t     k;
  ecsm_pkg::bitcnt_t   cnt;
  logic                acc_inf;
  logic                cur_inf;
  logic                pinf1;
  logic                pinf2;
  logic                p3_inf;
  logic                accept;
  logic                take;

  assign ins       = ecsm_pkg::ucode(pc);
  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_valid = (state == S_HOLD);
  assign res_inf   = acc_inf;

  assign cmd.go   = (state == S_EXEC);
  assign cmd.load = accept;
  assign cmd.op   = ins.op;
  assign cmd.dst  = ins.dst;
  assign cmd.s1   = ins.s1;
  assign cmd.s2   = ins.s2;

  always_comb begin
    case (ins.br)
      ecsm_pkg::BR_ALWAYS: take = 1'b1;
      ecsm_pkg::BR_CALL:   take = 1'b1;
      ecsm_pkg::BR_KZ:     take = !k[0];
      ecsm_pkg::BR_NLAST:  take = (cnt != '1);
      ecsm_pkg::BR_PINF1:  take = pinf1;
      ecsm_pkg::BR_PINF2:  take = pinf2;
      ecsm_pkg::BR_NE:     take = !sts.eq;
      ecsm_pkg::BR_Z1:     take = sts.z1;
      ecsm_pkg::BR_EZ:     take = sts.ez;
      ecsm_pkg::BR_E0Z:    take = !sts.e0;
      default:             take = 1'b0;
    endcase
    if (ins.br == ecsm_pkg::BR_RET) begin
      pc_next = ret;
    end else if (take) begin
      pc_next = ins.tgt;
    end else begin
      pc_next = pc + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      pc       <= '0;
      ret      <= '0;
      cnt      <= '0;
      acc_inf  <= 1'b1;
      cur_inf  <= 1'b0;
      pinf1    <= 1'b0;
      pinf2    <= 1'b0;
      p3_inf   <= 1'b0;
      on_curve <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (sts.m_small) begin
              acc_inf  <= 1'b1;
              on_curve <= 1'b0;
              state    <= S_HOLD;
            end else begin
              pc    <= '0;
              state <= S_FETCH;
            end
          end
        end
        S_FETCH: state <= S_EXEC;
        S_EXEC: begin
          case (ins.fl)
            ecsm_pkg::FL_ONC:   on_curve <= sts.eq;
            ecsm_pkg::FL_INIT: begin
              acc_inf <= 1'b1;
              cur_inf <= 1'b0;
              cnt     <= '0;
            end
            ecsm_pkg::FL_PACC: begin
              pinf1 <= acc_inf;
              pinf2 <= cur_inf;
            end
            ecsm_pkg::FL_PDBL: begin
              pinf1 <= cur_inf;
              pinf2 <= cur_inf;
            end
            ecsm_pkg::FL_ACCW:  acc_inf <= p3_inf;
            ecsm_pkg::FL_CURW:  cur_inf <= p3_inf;
            ecsm_pkg::FL_KSH:   cnt     <= cnt + 1'b1;
            ecsm_pkg::FL_P3FIN: p3_inf  <= 1'b0;
            ecsm_pkg::FL_P3INF: p3_inf  <= 1'b1;
            ecsm_pkg::FL_P3P2:  p3_inf  <= pinf2;
            default: ;
          endcase
          if (ins.op == ecsm_pkg::OP_MUL || ins.op == ecsm_pkg::OP_RED) begin
            state <= S_WAIT;
          end else if (ins.br == ecsm_pkg::BR_END) begin
            state <= S_HOLD;
          end else begin
            pc    <= pc_next;
            state <= S_FETCH;
            if (ins.br == ecsm_pkg::BR_CALL) begin
              ret <= pc + 6'd1;
            end
          end
        end
        S_WAIT: begin
          if (sts.mul_done) begin
            pc    <= pc + 6'd1;
            state <= S_FETCH;
          end
        end
        S_HOLD: begin
          if (!out_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The scalar is taken at accept and consumed one bit per loop pass.
  always_ff @(posedge clk) begin
    if (accept) begin
      k <= scalar;
    end else if (state == S_EXEC && ins.fl == ecsm_pkg::FL_KSH) begin
      k <= k >> 1;
    end
  end

  a_wait_holds_pc: assert property (@(posedge clk) disable iff (rst)
    (state == S_WAIT && !sts.mul_done) |=> (state == S_WAIT && $stable(pc)))
    else $error("pc moved while a multiply was outstanding");

  a_last_bit_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC && ins.br == ecsm_pkg::BR_NLAST && cnt == '1) |=> (pc == ecsm_pkg::PC_FIN))
    else $error("scalar loop did not finish after the last bit");

  a_hold_waits: assert property (@(posedge clk) disable iff (rst)
    (state == S_HOLD && out_stall) |=> (state == S_HOLD))
    else $error("result dropped while stalled");

endmodule

/* rtl/ec_point_scalar_multiply.sv */
// Top level: elliptic-curve scalar multiplication with on-curve check.
// One item runs up to two point operations per scalar bit over 32 scalar bits; a point
// addition that is not a special case uses Fermat inversion at a 32-bit modulus.
// Throughput: one item at a time, set by the single shared bit-serial multiplier.
// Reset (synchronous, active high) returns to idle with p = 23, a = 1, b = 1.
module ec_point_scalar_multiply (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  ecsm_pkg::word_t           point_x,
  input  ecsm_pkg::word_t           point_y,
  input  ecsm_pkg::word_t           scalar,
  output logic                      out_valid,
  input  logic                      out_stall,
  output ecsm_pkg::word_t           result_x,
  output ecsm_pkg::word_t           result_y,
  output logic                      result_at_infinity,
  output logic                      input_on_curve,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [1:0]                cfg_index,
  input  ecsm_pkg::word_t           cfg_data
);

  ecsm_pkg::cmd_t  cmd;
  ecsm_pkg::sts_t  sts;
  ecsm_pkg::word_t res_x;
  ecsm_pkg::word_t res_y;
  logic            res_inf;

  assign cfg_ready = 1'b1;

  ecsm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .scalar    (scalar),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts),
    .res_inf   (res_inf),
    .on_curve  (input_on_curve)
  );

  ecsm_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .point_x   (point_x),
    .point_y   (point_y),
    .cmd       (cmd),
    .sts       (sts),
    .res_x     (res_x),
    .res_y     (res_y)
  );

  // Coordinates read as zero when the result is the point at infinity.
  assign result_x           = res_inf ? '0 : res_x;
  assign result_y           = res_inf ? '0 : res_y;
  assign result_at_infinity = res_inf;

endmodule
